@@ hw/rtl/euler_to_quaternion_assert.svh @@
// ----------------------------------------------------------------------------
// euler_to_quaternion assertion macros
// Shared concurrent check macros, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef EULER_TO_QUATERNION_ASSERT_SVH
`define EULER_TO_QUATERNION_ASSERT_SVH

// same-cycle implication
`define E2Q_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("e2q same-cycle check failed");

// next-cycle implication
`define E2Q_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("e2q next-cycle check failed");

`endif

@@ hw/rtl/e2q_pkg.sv @@
// ----------------------------------------------------------------------------
// e2q_pkg
// Types, widths and the arctangent table of the Euler to quaternion block.
// ----------------------------------------------------------------------------
package e2q_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int NUM_CELLS     = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES
                                                                  : CORDIC_STAGES;
    localparam int PREP_LAT = 2;
    localparam int COMB_LAT = 4;
    localparam int LAT      = PREP_LAT + NUM_CELLS + COMB_LAT;

    localparam int ANGLE_W = 17;
    localparam int QUAT_W  = 16;
    localparam int CORD_W  = 34;
    localparam int TRIG_W  = 18;
    localparam int IDX_W   = 5;

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic signed [QUAT_W-1:0]  quat_t;
    typedef logic signed [CORD_W-1:0]  cord_t;
    typedef logic signed [TRIG_W-1:0]  trig_t;

    typedef struct packed {
        cord_t x;
        cord_t y;
    } rot_t;

    typedef struct packed {
        quat_t w;
        quat_t x;
        quat_t y;
        quat_t z;
    } quat4_t;

    localparam angle_t ANGLE_LIMIT = 17'sd46080;
    localparam cord_t  CORDIC_GAIN = 34'sd652032874;

    function automatic cord_t atan_of(logic [IDX_W-1:0] idx);
        case (idx)
            5'd0:    return 34'sh020000000;
            5'd1:    return 34'sh012E4051D;
            5'd2:    return 34'sh009FB385B;
            5'd3:    return 34'sh0051111D4;
            5'd4:    return 34'sh0028B0D43;
            5'd5:    return 34'sh00145D7E1;
            5'd6:    return 34'sh000A2F61E;
            5'd7:    return 34'sh000517C55;
            5'd8:    return 34'sh00028BE53;
            5'd9:    return 34'sh000145F2E;
            5'd10:   return 34'sh0000A2F98;
            5'd11:   return 34'sh0000517CC;
            5'd12:   return 34'sh000028BE6;
            5'd13:   return 34'sh0000145F3;
            5'd14:   return 34'sh00000A2F9;
            5'd15:   return 34'sh00000517C;
            5'd16:   return 34'sh0000028BE;
            5'd17:   return 34'sh00000145F;
            5'd18:   return 34'sh000000A2F;
            5'd19:   return 34'sh000000517;
            5'd20:   return 34'sh00000028B;
            5'd21:   return 34'sh000000145;
            5'd22:   return 34'sh0000000A2;
            5'd23:   return 34'sh000000051;
            default: return '0;
        endcase
    endfunction

endpackage

@@ hw/rtl/e2q_angle_prep.sv @@
// ----------------------------------------------------------------------------
// e2q_angle_prep
// Saturates one angle and converts its half angle to a 32-bit binary angle.
// ----------------------------------------------------------------------------
module e2q_angle_prep (
    input  logic            aclk,
    input  logic            en,
    input  e2q_pkg::angle_t angle,
    output e2q_pkg::cord_t  z0
);
    import e2q_pkg::*;

    angle_t        sat;
    angle_t        abs_v;
    logic [15:0]   mag;
    logic          neg_next;
    logic [30:0]   hi_next;
    logic [20:0]   n_next;
    logic          neg_reg;
    logic [30:0]   hi_reg;
    logic [20:0]   n_reg;
    logic [42:0]   prod;
    logic [31:0]   b;
    cord_t         z_next;
    cord_t         z_reg;

    always_comb begin
        if (angle > ANGLE_LIMIT) begin
            sat = ANGLE_LIMIT;
        end else if (angle < -ANGLE_LIMIT) begin
            sat = -ANGLE_LIMIT;
        end else begin
            sat = angle;
        end
        neg_next = sat[ANGLE_W-1];
        abs_v    = neg_next ? -sat : sat;
        mag      = abs_v[15:0];
        // 2^20 = 45 * 23301 + 31
        hi_next  = 31'(mag) * 31'd23301;
        n_next   = 21'(mag) * 21'd31 + 21'd22;
    end

    always_comb begin
        // floor(n / 45) by reciprocal
        prod   = 43'(n_reg) * 43'd2982617;
        b      = 32'(hi_reg) + 32'(prod[42:27]);
        z_next = neg_reg ? -cord_t'(b) : cord_t'(b);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_reg <= neg_next;
            hi_reg  <= hi_next;
            n_reg   <= n_next;
            z_reg   <= z_next;
        end
    end

    assign z0 = z_reg;

endmodule

@@ hw/rtl/e2q_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// e2q_cordic_cell
// One rotation-mode CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
module e2q_cordic_cell (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [e2q_pkg::IDX_W-1:0] idx,
    input  e2q_pkg::cord_t            x_in,
    input  e2q_pkg::cord_t            y_in,
    input  e2q_pkg::cord_t            z_in,
    output e2q_pkg::cord_t            x_out,
    output e2q_pkg::cord_t            y_out,
    output e2q_pkg::cord_t            z_out
);
    import e2q_pkg::*;

    cord_t dx;
    cord_t dy;
    cord_t x_next;
    cord_t y_next;
    cord_t z_next;
    cord_t x_reg;
    cord_t y_reg;
    cord_t z_reg;

    always_comb begin
        dx = y_in >>> idx;
        dy = x_in >>> idx;
        if (!z_in[CORD_W-1]) begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - atan_of(idx);
        end else begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + atan_of(idx);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

@@ hw/rtl/e2q_combine.sv @@
// ----------------------------------------------------------------------------
// e2q_combine
// Rounds the half-angle sines and cosines and forms the ZYX quaternion.
// ----------------------------------------------------------------------------
module e2q_combine (
    input  logic             aclk,
    input  logic             en,
    input  e2q_pkg::rot_t    roll,
    input  e2q_pkg::rot_t    pitch,
    input  e2q_pkg::rot_t    yaw,
    output e2q_pkg::quat4_t  quat
);
    import e2q_pkg::*;

    typedef logic signed [35:0] pair_t;
    typedef logic signed [53:0] trip_t;
    typedef logic signed [54:0] sum_t;

    function automatic trig_t round_trig(cord_t v);
        cord_t t;
        t = (v + cord_t'(34'sd8192)) >>> 14;
        if (t > 34'sd65536) begin
            return 18'sd65536;
        end else if (t < -34'sd65536) begin
            return -18'sd65536;
        end
        return t[TRIG_W-1:0];
    endfunction

    function automatic quat_t round_quat(sum_t v);
        sum_t t;
        t = (v + (55'sd1 <<< 33)) >>> 34;
        if (t > 55'sd16384) begin
            return 16'sd16384;
        end else if (t < -55'sd16384) begin
            return -16'sd16384;
        end
        return t[QUAT_W-1:0];
    endfunction

    trig_t  cr_reg, sr_reg, cp_reg, sp_reg, cy_reg, sy_reg;
    trig_t  cy2_reg, sy2_reg;
    pair_t  cc_reg, ss_reg, sc_reg, cs_reg;
    trip_t  w1_reg, w2_reg, x1_reg, x2_reg, y1_reg, y2_reg, z1_reg, z2_reg;
    quat4_t quat_next;
    quat4_t quat_reg;

    always_comb begin
        quat_next.w = round_quat(sum_t'(w1_reg) + sum_t'(w2_reg));
        quat_next.x = round_quat(sum_t'(x1_reg) - sum_t'(x2_reg));
        quat_next.y = round_quat(sum_t'(y1_reg) + sum_t'(y2_reg));
        quat_next.z = round_quat(sum_t'(z1_reg) - sum_t'(z2_reg));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cr_reg   <= round_trig(roll.x);
            sr_reg   <= round_trig(roll.y);
            cp_reg   <= round_trig(pitch.x);
            sp_reg   <= round_trig(pitch.y);
            cy_reg   <= round_trig(yaw.x);
            sy_reg   <= round_trig(yaw.y);
            cc_reg   <= cr_reg * cp_reg;
            ss_reg   <= sr_reg * sp_reg;
            sc_reg   <= sr_reg * cp_reg;
            cs_reg   <= cr_reg * sp_reg;
            cy2_reg  <= cy_reg;
            sy2_reg  <= sy_reg;
            w1_reg   <= cc_reg * cy2_reg;
            w2_reg   <= ss_reg * sy2_reg;
            x1_reg   <= sc_reg * cy2_reg;
            x2_reg   <= cs_reg * sy2_reg;
            y1_reg   <= cs_reg * cy2_reg;
            y2_reg   <= sc_reg * sy2_reg;
            z1_reg   <= cc_reg * sy2_reg;
            z2_reg   <= ss_reg * cy2_reg;
            quat_reg <= quat_next;
        end
    end

    assign quat = quat_reg;

endmodule

@@ hw/rtl/euler_to_quaternion.sv @@
// ----------------------------------------------------------------------------
// euler_to_quaternion
// ZYX Euler angles (1/256 degree) to a unit quaternion in Q2.14.
// ----------------------------------------------------------------------------
// Takes one roll/pitch/yaw request per clock while s_ready is high and
// returns the quaternion through 2 angle conversion stages, 16 CORDIC cells
// and 4 combine stages. Throughput is one request per cycle while the skid
// entry is empty, set by the fully pipelined CORDIC cell chain; an output
// register plus one skid entry lets the pipeline keep accepting while a result waits on m_ready.
module euler_to_quaternion (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  e2q_pkg::angle_t s_roll_angle,
    input  e2q_pkg::angle_t s_pitch_angle,
    input  e2q_pkg::angle_t s_yaw_angle,
    output logic            m_valid,
    input  logic            m_ready,
    output e2q_pkg::quat_t  m_quat_w,
    output e2q_pkg::quat_t  m_quat_x,
    output e2q_pkg::quat_t  m_quat_y,
    output e2q_pkg::quat_t  m_quat_z
);
    import e2q_pkg::*;

    logic           en;
    logic [LAT-1:0] vld_reg;
    angle_t         ang [3];
    cord_t          x_ch [3][NUM_CELLS+1];
    cord_t          y_ch [3][NUM_CELLS+1];
    cord_t          z_ch [3][NUM_CELLS+1];
    quat4_t         pipe_q;
    logic           pipe_v;
    logic           out_v_reg, out_v_next;
    logic           sk_v_reg, sk_v_next;
    quat4_t         out_reg, sk_reg;
    logic           load_out, load_sk, out_from_sk;

    assign en      = !sk_v_reg;
    assign s_ready = en;
    assign ang[0]  = s_roll_angle;
    assign ang[1]  = s_pitch_angle;
    assign ang[2]  = s_yaw_angle;
    assign pipe_v  = vld_reg[LAT-1];

    for (genvar a = 0; a < 3; a++) begin : g_axis
        e2q_angle_prep u_prep (
            .aclk  (aclk),
            .en    (en),
            .angle (ang[a]),
            .z0    (z_ch[a][0])
        );
        assign x_ch[a][0] = CORDIC_GAIN;
        assign y_ch[a][0] = '0;
        for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
            e2q_cordic_cell u_cell (
                .aclk  (aclk),
                .en    (en),
                .idx   (IDX_W'(k)),
                .x_in  (x_ch[a][k]),
                .y_in  (y_ch[a][k]),
                .z_in  (z_ch[a][k]),
                .x_out (x_ch[a][k+1]),
                .y_out (y_ch[a][k+1]),
                .z_out (z_ch[a][k+1])
            );
        end
    end

    e2q_combine u_combine (
        .aclk  (aclk),
        .en    (en),
        .roll  ('{x: x_ch[0][NUM_CELLS], y: y_ch[0][NUM_CELLS]}),
        .pitch ('{x: x_ch[1][NUM_CELLS], y: y_ch[1][NUM_CELLS]}),
        .yaw   ('{x: x_ch[2][NUM_CELLS], y: y_ch[2][NUM_CELLS]}),
        .quat  (pipe_q)
    );

    always_comb begin
        out_v_next  = out_v_reg;
        sk_v_next   = sk_v_reg;
        load_out    = 1'b0;
        load_sk     = 1'b0;
        out_from_sk = 1'b0;
        if (sk_v_reg) begin
            if (m_ready) begin
                out_from_sk = 1'b1;
                sk_v_next   = 1'b0;
            end
        end else begin
            if (out_v_reg && m_ready) begin
                out_v_next = 1'b0;
            end
            if (pipe_v) begin
                if (!out_v_reg || m_ready) begin
                    load_out   = 1'b1;
                    out_v_next = 1'b1;
                end else begin
                    load_sk   = 1'b1;
                    sk_v_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            out_v_reg <= 1'b0;
            sk_v_reg  <= 1'b0;
        end else begin
            if (en) begin
                vld_reg <= {vld_reg[LAT-2:0], s_valid};
            end
            out_v_reg <= out_v_next;
            sk_v_reg  <= sk_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_reg <= pipe_q;
        end else if (out_from_sk) begin
            out_reg <= sk_reg;
        end
        if (load_sk) begin
            sk_reg <= pipe_q;
        end
    end

    assign m_valid  = out_v_reg;
    assign m_quat_w = out_reg.w;
    assign m_quat_x = out_reg.x;
    assign m_quat_y = out_reg.y;
    assign m_quat_z = out_reg.z;

`include "euler_to_quaternion_assert.svh"

    `E2Q_ASSERT_IMP(a_skid_needs_out, sk_v_reg, out_v_reg)
    `E2Q_ASSERT_NEXT(a_skid_holds, sk_v_reg && !m_ready, sk_v_reg)
    `E2Q_ASSERT_NEXT(a_skid_loads, pipe_v && !sk_v_reg && out_v_reg && !m_ready, sk_v_reg)
    `E2Q_ASSERT_IMP(a_w_range, out_v_reg, out_reg.w <= 16'sd16384 && out_reg.w >= -16'sd16384)

endmodule
